[rtl/mma_pkg.sv]
package mma_pkg;

  // Width of every sample and average field on the channels.
  localparam int FIELD_BITS = 12;

  typedef logic [FIELD_BITS-1:0] field_t;

endpackage

[rtl/mma_channels.sv]
interface mma_sample_if;
  import mma_pkg::*;

  logic   valid;
  logic   ready;
  field_t knob_a_sample;
  field_t knob_b_sample;
  field_t knob_c_sample;
  field_t cv_sample;

  modport source (
    output valid, knob_a_sample, knob_b_sample, knob_c_sample, cv_sample,
    input  ready
  );
  modport sink (
    input  valid, knob_a_sample, knob_b_sample, knob_c_sample, cv_sample,
    output ready
  );
endinterface

interface mma_average_if;
  import mma_pkg::*;

  logic   valid;
  logic   ready;
  field_t knob_a_average;
  field_t knob_b_average;
  field_t knob_c_average;
  field_t cv_average;

  modport source (
    output valid, knob_a_average, knob_b_average, knob_c_average, cv_average,
    input  ready
  );
  modport sink (
    input  valid, knob_a_average, knob_b_average, knob_c_average, cv_average,
    output ready
  );
endinterface

[rtl/mma_ram.sv]
module mma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/mma_slide.sv]
module mma_slide #(
  parameter int WIN_LOG2    = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] leaving,
  output mma_pkg::field_t        average
);
  import mma_pkg::*;

  localparam int TOTAL_BITS = WIN_LOG2 + SAMPLE_BITS;
  localparam int EXT_BITS   = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

  logic [TOTAL_BITS-1:0] total_r;
  logic [TOTAL_BITS-1:0] total_nxt;
  logic [EXT_BITS-1:0]   avg_ext;

  // Add the arriving sample, drop the one leaving the window.
  assign total_nxt = total_r + TOTAL_BITS'(sample) - TOTAL_BITS'(leaving);
  assign avg_ext   = EXT_BITS'(total_nxt[WIN_LOG2 +: SAMPLE_BITS]);
  assign average   = avg_ext[FIELD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (step) begin
      total_r <= total_nxt;
    end
  end

endmodule

[rtl/multichannel_moving_average.sv]
// Four-channel boxcar moving average (three knobs, one control voltage).
//
// in_ch carries one beat per control tick with a sample for each channel;
// out_ch returns exactly one beat of averages for every input beat, in order.
// Knob averages span 2^KNOB_WINDOW_LOG2 samples, the CV average spans
// 2^CV_WINDOW_LOG2 samples; each is the running sum shifted right, truncated.
//
// An accepted input beat passes the input stage, then the result register.
// Throughput: one beat per cycle unless out_ch stalls. The pace is set by the
// history RAMs: the leaving sample is read when a beat is accepted (the write
// position is a counter, so its address is known in advance) and the new
// sample is written on stage advance; the running sums update in that stage.
//
// Reset clears sums, write position and the per-ring "filled" flags; until a
// ring has been written once its leaving sample reads as zero, so the first
// window averages in zeros. No clearing pass is needed, in_ch is ready
// straight out of reset.
//
// If out_ch stalls, the result register holds and one more beat is held in
// the input stage; in_ch.ready drops only when both are occupied.
module multichannel_moving_average #(
  parameter int KNOB_WINDOW_LOG2 = 8,
  parameter int CV_WINDOW_LOG2   = 4,
  parameter int SAMPLE_BITS      = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  mma_sample_if.sink    in_ch,
  mma_average_if.source out_ch
);
  import mma_pkg::*;

  localparam int RING_BITS = (KNOB_WINDOW_LOG2 > CV_WINDOW_LOG2) ?
                             KNOB_WINDOW_LOG2 : CV_WINDOW_LOG2;
  localparam int EXT_BITS  = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam int KNOBS     = 3;

  // Input side: mask samples to SAMPLE_BITS.
  logic [EXT_BITS-1:0]    in_ext [KNOBS+1];
  logic [SAMPLE_BITS-1:0] in_sample [KNOBS+1];
  logic                   in_acc;

  assign in_ext[0] = EXT_BITS'(in_ch.knob_a_sample);
  assign in_ext[1] = EXT_BITS'(in_ch.knob_b_sample);
  assign in_ext[2] = EXT_BITS'(in_ch.knob_c_sample);
  assign in_ext[3] = EXT_BITS'(in_ch.cv_sample);

  for (genvar i = 0; i <= KNOBS; i++) begin : g_mask
    assign in_sample[i] = in_ext[i][SAMPLE_BITS-1:0];
  end

  // Shared write position and ring-filled flags.
  logic [RING_BITS-1:0] ring_pos_r;
  logic                 knob_full_r;
  logic                 cv_full_r;

  // Input stage.
  logic                        s1_valid_r;
  logic [SAMPLE_BITS-1:0]      s1_sample_r [KNOBS+1];
  logic [KNOB_WINDOW_LOG2-1:0] s1_kslot_r;
  logic [CV_WINDOW_LOG2-1:0]   s1_cslot_r;
  logic                        s1_knob_old_r;
  logic                        s1_cv_old_r;
  logic                        s1_adv;

  // Result register.
  logic   out_valid_r;
  field_t avg_r [KNOBS+1];
  field_t avg_nxt [KNOBS+1];

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_pos_r  <= '0;
      knob_full_r <= 1'b0;
      cv_full_r   <= 1'b0;
    end else if (in_acc) begin
      ring_pos_r <= ring_pos_r + 1'b1;
      // Once the last slot of a ring is taken, every slot holds real history.
      if (&ring_pos_r[KNOB_WINDOW_LOG2-1:0]) begin
        knob_full_r <= 1'b1;
      end
      if (&ring_pos_r[CV_WINDOW_LOG2-1:0]) begin
        cv_full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload of the input stage; hold while stalled.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r   <= in_sample;
      s1_kslot_r    <= ring_pos_r[KNOB_WINDOW_LOG2-1:0];
      s1_cslot_r    <= ring_pos_r[CV_WINDOW_LOG2-1:0];
      s1_knob_old_r <= knob_full_r;
      s1_cv_old_r   <= cv_full_r;
    end
  end

  // History rings: the three knobs share one RAM word, the CV has its own.
  // Read the leaving sample at accept, write the new one as the stage advances.
  logic [KNOBS*SAMPLE_BITS-1:0] knob_rd_data;
  logic [KNOBS*SAMPLE_BITS-1:0] knob_wr_data;
  logic [SAMPLE_BITS-1:0]       cv_rd_data;

  assign knob_wr_data = {s1_sample_r[2], s1_sample_r[1], s1_sample_r[0]};

  mma_ram #(
    .WIDTH (KNOBS * SAMPLE_BITS),
    .DEPTH (1 << KNOB_WINDOW_LOG2)
  ) u_knob_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_kslot_r),
    .wr_data (knob_wr_data),
    .rd_en   (in_acc),
    .rd_addr (ring_pos_r[KNOB_WINDOW_LOG2-1:0]),
    .rd_data (knob_rd_data)
  );

  mma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << CV_WINDOW_LOG2)
  ) u_cv_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_cslot_r),
    .wr_data (s1_sample_r[KNOBS]),
    .rd_en   (in_acc),
    .rd_addr (ring_pos_r[CV_WINDOW_LOG2-1:0]),
    .rd_data (cv_rd_data)
  );

  // Leaving samples: zero until the ring has been written once.
  logic [SAMPLE_BITS-1:0] leaving [KNOBS+1];

  for (genvar i = 0; i < KNOBS; i++) begin : g_knob
    assign leaving[i] = s1_knob_old_r ? knob_rd_data[i*SAMPLE_BITS +: SAMPLE_BITS] : '0;

    mma_slide #(
      .WIN_LOG2    (KNOB_WINDOW_LOG2),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_slide (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (s1_adv),
      .sample  (s1_sample_r[i]),
      .leaving (leaving[i]),
      .average (avg_nxt[i])
    );
  end

  assign leaving[KNOBS] = s1_cv_old_r ? cv_rd_data : '0;

  mma_slide #(
    .WIN_LOG2    (CV_WINDOW_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cv_slide (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .sample  (s1_sample_r[KNOBS]),
    .leaving (leaving[KNOBS]),
    .average (avg_nxt[KNOBS])
  );

  // Result register: load as the stage advances, drop valid when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      avg_r <= avg_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.knob_a_average = avg_r[0];
  assign out_ch.knob_b_average = avg_r[1];
  assign out_ch.knob_c_average = avg_r[2];
  assign out_ch.cv_average     = avg_r[KNOBS];

  // Input backpressure only when both the stage and the result are full.
  a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while a slot was free");

  // Every accepted beat lands in the input stage.
  a_accept_fills_stage : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted beat lost");

  // The write position steps by exactly one per accepted beat.
  a_pos_steps : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && rst_n |=> ring_pos_r == RING_BITS'($past(ring_pos_r) + 1'b1))
    else $error("ring position out of step");

  // The knob ring's filled flag stays set until reset.
  a_full_sticky : assert property (@(posedge clk)
    knob_full_r && rst_n |=> knob_full_r)
    else $error("knob ring filled flag dropped");

endmodule
